### rtl/lpbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpbp_pkg: shared types and constants of the page buffer pool
// frame counts, field widths, word structs and controller handshake
// ----------------------------------------------------------------------------
package lpbp_pkg;

   localparam int NUM_FRAMES  = 16;
   localparam int NUM_TABLES  = 10;

   // fixed field widths of the word formats
   localparam int CMD_W       = 1;
   localparam int TABLE_W     = 4;
   localparam int PAGE_W      = 32;
   localparam int FRM_FIELD_W = 5;

   // internal widths derived from the frame count
   localparam int IDX_W   = $clog2(NUM_FRAMES);
   localparam int FRAME_W = $clog2(NUM_FRAMES + 1);
   localparam int CMP_W   = (FRAME_W > FRM_FIELD_W) ? FRAME_W : FRM_FIELD_W;

   localparam logic [FRM_FIELD_W-1:0] CFG_RESET = FRM_FIELD_W'(16);

   localparam logic [CMD_W-1:0] CMD_ACCESS = 1'b0;
   localparam logic [CMD_W-1:0] CMD_DIRTY  = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]       command;
      logic [TABLE_W-1:0]     tbl_id;
      logic [PAGE_W-1:0]      page_num;
      logic [FRM_FIELD_W-1:0] dirty_frame;
   } req_type;

   typedef struct packed {
      logic [FRM_FIELD_W-1:0] frame_index;
      logic                   hit;
      logic                   fill_needed;
      logic                   evicted;
      logic                   writeback;
      logic [TABLE_W-1:0]     victim_table;
      logic [PAGE_W-1:0]      victim_page;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic look;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

### rtl/lpbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpbp_ctrl: request sequencer
// steps each request through capture, lookup and update
// ----------------------------------------------------------------------------
module lpbp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire lpbp_pkg::dp_status_type status,
   output lpbp_pkg::dp_cmd_type         cmd
);
   import lpbp_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
         end
         ST_UPDATE: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/lpbp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpbp_datapath: tag store, recency ranks and result register
// parallel tag match, lru victim pick and list update
// ----------------------------------------------------------------------------
module lpbp_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lpbp_pkg::dp_cmd_type                cmd,
   output lpbp_pkg::dp_status_type                  status,
   input  wire lpbp_pkg::req_type                   req_data,
   input  wire logic                                csr_write_enable,
   input  wire logic [lpbp_pkg::FRM_FIELD_W-1:0]    csr_write_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output lpbp_pkg::rsp_type                        rsp_data
);
   import lpbp_pkg::*;

   // captured request and configuration
   req_type                req_ff, req_in;
   logic [FRM_FIELD_W-1:0] limit_cfg_ff, limit_cfg_in;
   logic [FRAME_W-1:0]     used_ff, used_in;

   // per-frame state, rank 0 is most recently used
   logic [TABLE_W-1:0]    tag_table_ff [NUM_FRAMES];
   logic [TABLE_W-1:0]    tag_table_in [NUM_FRAMES];
   logic [PAGE_W-1:0]     tag_page_ff  [NUM_FRAMES];
   logic [PAGE_W-1:0]     tag_page_in  [NUM_FRAMES];
   logic [IDX_W-1:0]      rank_ff      [NUM_FRAMES];
   logic [IDX_W-1:0]      rank_in      [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] dirty_ff, dirty_in;

   // lookup results
   logic                  hit_ff, hit_in;
   logic [NUM_FRAMES-1:0] tgt_oh_ff, tgt_oh_in;
   logic [IDX_W-1:0]      tgt_idx_ff, tgt_idx_in;
   logic [IDX_W-1:0]      tgt_rank_ff, tgt_rank_in;
   logic [TABLE_W-1:0]    vic_table_ff, vic_table_in;
   logic [PAGE_W-1:0]     vic_page_ff, vic_page_in;
   logic                  vic_dirty_ff, vic_dirty_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic [NUM_FRAMES-1:0] valid_vec;
   logic [NUM_FRAMES-1:0] match_oh;
   logic [NUM_FRAMES-1:0] head_oh;
   logic                  match_any;
   logic [IDX_W-1:0]      head_rank;
   logic                  tbl_ok;
   logic [CMP_W-1:0]      limit_cmp;
   logic [CMP_W-1:0]      used_ext;
   logic                  room;
   logic                  df_ok;
   logic [IDX_W-1:0]      df_idx;

   assign head_rank = IDX_W'(used_ff - FRAME_W'(1));
   assign used_ext  = CMP_W'(used_ff);

   always_comb begin
      if (limit_cfg_ff == '0) begin
         limit_cmp = CMP_W'(1);
      end else if (CMP_W'(limit_cfg_ff) > CMP_W'(NUM_FRAMES)) begin
         limit_cmp = CMP_W'(NUM_FRAMES);
      end else begin
         limit_cmp = CMP_W'(limit_cfg_ff);
      end
   end

   assign room   = used_ext < limit_cmp;
   assign tbl_ok = (req_ff.tbl_id != '0) && (req_ff.tbl_id <= TABLE_W'(NUM_TABLES));
   assign df_ok  = (req_ff.dirty_frame != '0) && (CMP_W'(req_ff.dirty_frame) <= used_ext);
   assign df_idx = IDX_W'(CMP_W'(req_ff.dirty_frame) - CMP_W'(1));

   always_comb begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
         valid_vec[i] = FRAME_W'(i) < used_ff;
      end
   end

   // tag match with lowest-frame priority, and lru head by rank
   always_comb begin
      logic seen;
      logic m;
      seen     = 1'b0;
      match_oh = '0;
      head_oh  = '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         m = valid_vec[i] && (tag_table_ff[i] == req_ff.tbl_id)
             && (tag_page_ff[i] == req_ff.page_num);
         match_oh[i] = m && !seen;
         seen        = seen | m;
         head_oh[i]  = valid_vec[i] && (rank_ff[i] == head_rank);
      end
      match_any = seen;
   end

   always_comb begin
      hit_in       = hit_ff;
      tgt_oh_in    = tgt_oh_ff;
      tgt_idx_in   = tgt_idx_ff;
      tgt_rank_in  = tgt_rank_ff;
      vic_table_in = vic_table_ff;
      vic_page_in  = vic_page_ff;
      vic_dirty_in = vic_dirty_ff;
      if (cmd.look) begin
         hit_in       = match_any;
         tgt_oh_in    = match_any ? match_oh : head_oh;
         tgt_idx_in   = '0;
         tgt_rank_in  = '0;
         vic_table_in = '0;
         vic_page_in  = '0;
         vic_dirty_in = 1'b0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            if (tgt_oh_in[i]) begin
               tgt_idx_in  = tgt_idx_in | IDX_W'(i);
               tgt_rank_in = tgt_rank_in | rank_ff[i];
            end
            if (head_oh[i]) begin
               vic_table_in = vic_table_in | tag_table_ff[i];
               vic_page_in  = vic_page_in | tag_page_ff[i];
               vic_dirty_in = vic_dirty_in | dirty_ff[i];
            end
         end
      end
   end

   // state update and result build
   always_comb begin
      req_in       = cmd.load ? req_data : req_ff;
      limit_cfg_in = csr_write_enable ? csr_write_data : limit_cfg_ff;
      used_in      = used_ff;
      tag_table_in = tag_table_ff;
      tag_page_in  = tag_page_ff;
      rank_in      = rank_ff;
      dirty_in     = dirty_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (req_ff.command == CMD_DIRTY) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
               if (df_ok && (IDX_W'(i) == df_idx)) dirty_in[i] = 1'b1;
            end
         end else if (tbl_ok) begin
            if (hit_ff || !room) begin
               // move hit or victim frame to the mru end
               for (int i = 0; i < NUM_FRAMES; i++) begin
                  if (valid_vec[i] && (rank_ff[i] < tgt_rank_ff)) begin
                     rank_in[i] = rank_ff[i] + IDX_W'(1);
                  end
                  if (tgt_oh_ff[i]) begin
                     rank_in[i] = '0;
                     if (!hit_ff) begin
                        tag_table_in[i] = req_ff.tbl_id;
                        tag_page_in[i]  = req_ff.page_num;
                        dirty_in[i]     = 1'b0;
                     end
                  end
               end
               rsp_in.frame_index = FRM_FIELD_W'(FRAME_W'(tgt_idx_ff) + FRAME_W'(1));
               rsp_in.hit         = hit_ff;
               rsp_in.fill_needed = !hit_ff;
               rsp_in.evicted     = !hit_ff;
               if (!hit_ff) begin
                  rsp_in.writeback    = vic_dirty_ff;
                  rsp_in.victim_table = vic_table_ff;
                  rsp_in.victim_page  = vic_page_ff;
               end
            end else begin
               // take the next unused frame
               for (int i = 0; i < NUM_FRAMES; i++) begin
                  if (valid_vec[i]) rank_in[i] = rank_ff[i] + IDX_W'(1);
                  if (FRAME_W'(i) == used_ff) begin
                     rank_in[i]      = '0;
                     tag_table_in[i] = req_ff.tbl_id;
                     tag_page_in[i]  = req_ff.page_num;
                     dirty_in[i]     = 1'b0;
                  end
               end
               used_in            = used_ff + FRAME_W'(1);
               rsp_in.frame_index = FRM_FIELD_W'(used_ff + FRAME_W'(1));
               rsp_in.fill_needed = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_cfg_ff <= CFG_RESET;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_cfg_ff <= limit_cfg_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      tag_table_ff <= tag_table_in;
      tag_page_ff  <= tag_page_in;
      rank_ff      <= rank_in;
      dirty_ff     <= dirty_in;
      hit_ff       <= hit_in;
      tgt_oh_ff    <= tgt_oh_in;
      tgt_idx_ff   <= tgt_idx_in;
      tgt_rank_ff  <= tgt_rank_in;
      vic_table_ff <= vic_table_in;
      vic_page_ff  <= vic_page_in;
      vic_dirty_ff <= vic_dirty_in;
      rsp_ff       <= rsp_in;
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FRAME_W'(NUM_FRAMES))
      else $error("frame count beyond pool size");

   a_head_unique: assert property (@(posedge clock) disable iff (reset)
      cmd.look && (used_ff != '0) |-> $onehot(head_oh))
      else $error("recency ranks are not a permutation");

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hit |-> !rsp_ff.fill_needed && !rsp_ff.evicted)
      else $error("hit result carries miss flags");

   a_wb_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.writeback |-> rsp_ff.evicted && rsp_ff.fill_needed)
      else $error("write-back without eviction");

endmodule
`default_nettype wire

### rtl/lru_page_buffer_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_buffer_pool: page cache frame allocator with lru replacement
// maps (table, page) to one of the buffer frames, reports evictions
// ----------------------------------------------------------------------------
// usage
//   req_ channel carries one request word: access a page or mark a frame dirty
//   rsp_ channel returns exactly one result word per request, in order
//   csr_ port writes the frames-in-use limit; write only while the pool is idle
// request flow
//   a request passes capture, parallel tag match over all frames with lru head
//   pick, then the tag and recency update; one request is in flight, so the
//   pool takes no new request until the update of the last one is done
//   the result sits in an output register, so the next request is accepted
//   while the previous word still waits on rsp_stall
// reset
//   synchronous, active high; the pool comes up empty with the limit at 16,
//   no clearing pass is needed
// stall
//   while rsp_stall holds the result, the next request finishes its lookup
//   and then waits before touching state
// ----------------------------------------------------------------------------
module lru_page_buffer_pool (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire lpbp_pkg::req_type                 req_data,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output lpbp_pkg::rsp_type                      rsp_data,
   // configuration
   input  wire logic                              csr_write_enable,
   input  wire logic [lpbp_pkg::FRM_FIELD_W-1:0]  csr_write_data
);
   import lpbp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: capture, lookup, update
   lpbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // tags, recency ranks, dirty bits and result register
   lpbp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule
`default_nettype wire
